@@ design/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and codes for the periodic alarm table.
// ----------------------------------------------------------------------------
`default_nettype none
package pat_pkg;
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_BAD   = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;
    localparam logic [1:0] KIND_FIRED = 2'd3;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_RESULTS = 16;
    localparam logic [32:0] FIRE_GAP = 33'd60;

    typedef struct packed {
        logic load;
        logic write_entry;
        logic append;
        logic scan_start;
        logic scan_step;
        logic shift_step;
        logic fire;
        logic dec_count;
        logic emit;
        logic emit_last;
        logic [1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic index_bad;
        logic full;
        logic scan_done;
        logic mod_busy;
        logic hit;
        logic shift_done;
    } t_status;
endpackage
`default_nettype wire

@@ design/pat_ctrl.sv @@
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer: decodes the operation and walks entries for tick and remove.
// ----------------------------------------------------------------------------
`default_nettype none
module pat_ctrl
    import pat_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_start,
    input  t_status i_status,
    output logic    o_busy,
    output t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DEC   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_SHIFT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_any, n_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_any   <= n_any;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_any   = r_any;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.emit_last = 1'b1;
                case (i_status.op)
                    OP_TICK: begin
                        o_cmd.emit_last  = 1'b0;
                        o_cmd.scan_start = 1'b1;
                        n_any            = 1'b0;
                        n_state          = S_SCAN;
                    end
                    OP_ADD: begin
                        o_cmd.emit = 1'b1;
                        if (i_status.full) begin
                            o_cmd.kind = KIND_FULL;
                        end else begin
                            o_cmd.write_entry = 1'b1;
                            o_cmd.append      = 1'b1;
                            o_cmd.kind        = KIND_DONE;
                        end
                        n_state = S_IDLE;
                    end
                    OP_SET: begin
                        o_cmd.emit = 1'b1;
                        if (i_status.index_bad) begin
                            o_cmd.kind = KIND_BAD;
                        end else begin
                            o_cmd.write_entry = 1'b1;
                            o_cmd.kind        = KIND_DONE;
                        end
                        n_state = S_IDLE;
                    end
                    default: begin
                        if (i_status.index_bad) begin
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = KIND_BAD;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.emit_last = 1'b0;
                            n_state         = S_SHIFT;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.kind      = r_any ? KIND_FIRED : KIND_DONE;
                    n_state         = S_IDLE;
                end else if (!i_status.mod_busy) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.hit) begin
                    // a held fired transaction leaves once the next hit is known
                    o_cmd.fire = 1'b1;
                    o_cmd.emit = r_any;
                    o_cmd.kind = KIND_FIRED;
                    n_any      = 1'b1;
                end
                n_state = S_SCAN;
            end
            S_SHIFT: begin
                if (i_status.shift_done) begin
                    o_cmd.dec_count = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.kind      = KIND_DONE;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    property p_emit_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.emit |-> o_busy;
    endproperty
    a_emit_busy: assert property (p_emit_busy) else $error("emit while idle");

    property p_load_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.load |=> (r_state == S_DEC);
    endproperty
    a_load_idle: assert property (p_load_idle) else $error("load did not decode");

    property p_fire_eval;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.fire |-> (r_state == S_EVAL);
    endproperty
    a_fire_eval: assert property (p_fire_eval) else $error("fire outside evaluation");
endmodule
`default_nettype wire

@@ design/pat_datapath.sv @@
// ----------------------------------------------------------------------------
// pat_datapath
// Entry storage, clamping, match test with a subtract-based modulo and results.
// ----------------------------------------------------------------------------
`default_nettype none
module pat_datapath
    import pat_pkg::*;
#(
    parameter int MAX_PERIOD_DAYS = 7
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  wire  [1:0]  i_op,
    input  wire  [3:0]  i_entry_index,
    input  wire  [7:0]  i_new_hour,
    input  wire  [7:0]  i_new_minute,
    input  wire  [7:0]  i_new_amount,
    input  wire  [7:0]  i_new_period,
    input  wire         i_new_enabled,
    input  wire         i_clock_valid,
    input  wire  [4:0]  i_now_hour,
    input  wire  [5:0]  i_now_minute,
    input  wire  [19:0] i_day_number,
    input  wire  [31:0] i_now_seconds,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_fired_index,
    output logic [2:0]  o_fired_amount,
    output logic [4:0]  o_entries_used,
    output logic        o_last_result
);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
    localparam logic [7:0] MAXP = 8'(MAX_PERIOD_DAYS);

    logic [4:0]  r_hour   [TABLE_ENTRIES];
    logic [5:0]  r_minute [TABLE_ENTRIES];
    logic [2:0]  r_amount [TABLE_ENTRIES];
    logic [7:0]  r_period [TABLE_ENTRIES];
    logic        r_en     [TABLE_ENTRIES];
    logic [31:0] r_last   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_last_ok;

    logic [CW-1:0] r_count;
    logic [1:0]    r_op;
    logic [3:0]    r_idx;
    logic [7:0]    r_h, r_m, r_a, r_p;
    logic          r_ne, r_cv;
    logic [4:0]    r_nh;
    logic [5:0]    r_nm;
    logic [19:0]   r_day;
    logic [31:0]   r_now;
    logic [CW-1:0] r_ptr;
    logic [4:0]    r_nres;
    logic [19:0]   r_rem;
    logic          r_modbusy;
    logic [3:0]    r_pidx;
    logic [2:0]    r_pamt;

    logic [IW-1:0] ptr_i, pos_i;
    logic [CW-1:0] pos;
    logic [4:0]    c_h;
    logic [5:0]    c_m;
    logic [2:0]    c_a;
    logic [7:0]    c_p;
    logic [31:0]   cur_last;
    logic          time_ok, shift_last, rem_ge;
    logic [19:0]   per_ext;

    assign ptr_i    = r_ptr[IW-1:0];
    assign pos      = (r_op == OP_ADD) ? r_count : CW'(r_idx);
    assign pos_i    = pos[IW-1:0];
    assign c_h      = (r_h > 8'd23) ? 5'd0 : r_h[4:0];
    assign c_m      = (r_m > 8'd59) ? 6'd0 : r_m[5:0];
    assign c_a      = (r_a < 8'd1) ? 3'd1 : (r_a > 8'd6) ? 3'd6 : r_a[2:0];
    assign c_p      = (r_p < 8'd1) ? 8'd1 : (r_p > MAXP) ? MAXP : r_p;
    assign cur_last = r_last_ok[ptr_i] ? r_last[ptr_i] : 32'd0;
    assign time_ok  = {1'b0, r_now} >= ({1'b0, cur_last} + FIRE_GAP);
    assign per_ext  = {12'd0, r_period[ptr_i]};
    assign rem_ge   = r_rem >= per_ext;
    assign shift_last = (r_ptr + CW'(1)) >= r_count;

    assign o_status.op         = r_op;
    assign o_status.index_bad  = CW'(r_idx) >= r_count || {1'b0, r_idx} >= 5'(TABLE_ENTRIES);
    assign o_status.full       = r_count >= FULL_COUNT;
    assign o_status.scan_done  = !r_cv || r_ptr >= r_count || r_nres >= 5'(MAX_RESULTS);
    assign o_status.mod_busy   = r_modbusy;
    assign o_status.hit        = r_en[ptr_i] && r_hour[ptr_i] == r_nh
                                 && r_minute[ptr_i] == r_nm && r_rem == 20'd0 && time_ok;
    assign o_status.shift_done = shift_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_idx <= i_entry_index;
            r_h <= i_new_hour; r_m <= i_new_minute; r_a <= i_new_amount; r_p <= i_new_period;
            r_ne <= i_new_enabled; r_cv <= i_clock_valid;
            r_nh <= i_now_hour; r_nm <= i_now_minute; r_day <= i_day_number;
            r_now <= i_now_seconds;
        end
        if (i_cmd.write_entry) begin
            r_hour[pos_i] <= c_h; r_minute[pos_i] <= c_m; r_amount[pos_i] <= c_a;
            r_period[pos_i] <= c_p; r_en[pos_i] <= r_ne;
        end
        if (i_cmd.shift_step) begin
            r_hour[ptr_i]   <= r_hour[IW'(r_ptr + CW'(1))];
            r_minute[ptr_i] <= r_minute[IW'(r_ptr + CW'(1))];
            r_amount[ptr_i] <= r_amount[IW'(r_ptr + CW'(1))];
            r_period[ptr_i] <= r_period[IW'(r_ptr + CW'(1))];
            r_en[ptr_i]     <= r_en[IW'(r_ptr + CW'(1))];
            r_last[ptr_i]   <= r_last_ok[IW'(r_ptr + CW'(1))]
                               ? r_last[IW'(r_ptr + CW'(1))] : 32'd0;
        end
        if (i_cmd.fire) begin
            r_last[ptr_i] <= r_now;
            r_pidx        <= 4'(r_ptr);
            r_pamt        <= r_amount[ptr_i];
        end
        if (i_cmd.emit) begin
            o_result_kind  <= i_cmd.kind;
            o_fired_index  <= (i_cmd.kind == KIND_FIRED) ? r_pidx : 4'd0;
            o_fired_amount <= (i_cmd.kind == KIND_FIRED) ? r_pamt : 3'd0;
            o_entries_used <= i_cmd.append ? 5'(r_count + CW'(1))
                            : i_cmd.dec_count ? 5'(r_count - CW'(1)) : 5'(r_count);
            o_last_result  <= i_cmd.emit_last;
        end
        if (i_cmd.scan_start || i_cmd.scan_step) begin
            r_rem <= r_day;
        end else if (r_modbusy && rem_ge) begin
            r_rem <= r_rem - per_ext;
        end
        if (!i_rst_n) begin
            r_count <= '0; r_last_ok <= '0; r_ptr <= '0; r_nres <= '0;
            r_modbusy <= 1'b0; o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
                r_last_ok[pos_i] <= 1'b0;
            end
            if (i_cmd.dec_count) r_count <= r_count - CW'(1);
            if (i_cmd.fire) begin
                r_last_ok[ptr_i] <= 1'b1;
                r_nres <= r_nres + 5'd1;
            end
            if (i_cmd.shift_step) begin
                r_last_ok[ptr_i] <= 1'b1;
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_cmd.load) begin
                r_ptr  <= CW'(i_entry_index);
                r_nres <= '0;
            end
            if (i_cmd.scan_start) begin
                r_ptr <= '0;
                r_modbusy <= 1'b1;
            end else if (i_cmd.scan_step) begin
                r_ptr <= r_ptr + CW'(1);
                r_modbusy <= 1'b1;
            end else if (r_modbusy && !rem_ge) begin
                r_modbusy <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/periodic_alarm_table.sv @@
// ----------------------------------------------------------------------------
// periodic_alarm_table
// Table of periodic alarms with add, set, remove and a firing tick.
// ----------------------------------------------------------------------------
// add and set decode the operation, then register their result
// remove shifts each entry after the index down by one, then gives its result
// tick walks each entry; day modulo period is a repeated subtract for each
// entry; a fired transaction leaves at the next hit or at the end of the walk;
// busy stays high through each final result cycle
// synchronous active-low reset empties the table; no clearing pass
`default_nettype none
module periodic_alarm_table
    import pat_pkg::*;
#(
    parameter int MAX_PERIOD_DAYS = 7
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_op,
    input  wire  [3:0]  i_entry_index,
    input  wire  [7:0]  i_new_hour,
    input  wire  [7:0]  i_new_minute,
    input  wire  [7:0]  i_new_amount,
    input  wire  [7:0]  i_new_period,
    input  wire         i_new_enabled,
    input  wire         i_clock_valid,
    input  wire  [4:0]  i_now_hour,
    input  wire  [5:0]  i_now_minute,
    input  wire  [19:0] i_day_number,
    input  wire  [31:0] i_now_seconds,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic [3:0]  o_fired_index,
    output logic [2:0]  o_fired_amount,
    output logic [4:0]  o_entries_used,
    output logic        o_last_result
);
    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy, r_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tail <= 1'b0;
        else          r_tail <= cmd.emit;
    end
    assign busy = ctrl_busy || r_tail;

    pat_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_status(status), .o_busy(ctrl_busy), .o_cmd(cmd)
    );

    pat_datapath #(
        .MAX_PERIOD_DAYS(MAX_PERIOD_DAYS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_op(i_op), .i_entry_index(i_entry_index), .i_new_hour(i_new_hour),
        .i_new_minute(i_new_minute), .i_new_amount(i_new_amount),
        .i_new_period(i_new_period), .i_new_enabled(i_new_enabled),
        .i_clock_valid(i_clock_valid), .i_now_hour(i_now_hour),
        .i_now_minute(i_now_minute), .i_day_number(i_day_number),
        .i_now_seconds(i_now_seconds), .o_result_valid(o_result_valid),
        .o_result_kind(o_result_kind), .o_fired_index(o_fired_index),
        .o_fired_amount(o_fired_amount), .o_entries_used(o_entries_used),
        .o_last_result(o_last_result)
    );
endmodule
`default_nettype wire
